>>> rtl/wbps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants of the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
package wbps_pkg;

	localparam int PAT_MAX = 16;                    // window / pattern bytes
	localparam int IDX_W   = $clog2(PAT_MAX);       // index of one pattern byte
	localparam int LEN_W   = $clog2(PAT_MAX + 1);   // holds 0..PAT_MAX
	localparam int CNT_W   = 32;                    // byte counter / offset
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_LEN_W  = 5;                  // stored pattern_length bits

	typedef logic [PAT_MAX-1:0][7:0] byte_vec_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LOW  = 8'd0,
		REG_PATTERN_HIGH = 8'd1,
		REG_CARE_MASK    = 8'd2,
		REG_PATTERN_LEN  = 8'd3
	} cfg_reg_t;

	typedef struct packed {
		logic             found;
		logic [CNT_W-1:0] offset;
	} result_t;

endpackage

>>> rtl/wbps_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbps_match
// Parallel compare of the byte window against the masked pattern.
// ----------------------------------------------------------------------------
module wbps_match (
	input  wbps_pkg::byte_vec_t           win,       // entry 0 is newest
	input  wbps_pkg::byte_vec_t           pattern,
	input  logic [wbps_pkg::PAT_MAX-1:0]  care,
	input  logic [wbps_pkg::LEN_W-1:0]    used_len,
	output logic                          match
);

	logic [wbps_pkg::PAT_MAX-1:0] ok;

	// window entry p lines up with pattern byte used_len-1-p
	always_comb begin
		logic [wbps_pkg::LEN_W-1:0] j;
		j  = '0;
		ok = '0;
		for (int p = 0; p < wbps_pkg::PAT_MAX; p++) begin
			j = used_len - wbps_pkg::LEN_W'(p) - wbps_pkg::LEN_W'(1);
			ok[p] = (wbps_pkg::LEN_W'(p) >= used_len)
				|| !care[j[wbps_pkg::IDX_W-1:0]]
				|| (win[p] == pattern[j[wbps_pkg::IDX_W-1:0]]);
		end
	end

	assign match = (used_len != '0) && (&ok);

endmodule

>>> rtl/wbps_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbps_out_buf
// Two-entry result buffer; decouples the scan from the result receiver.
// ----------------------------------------------------------------------------
module wbps_out_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  wbps_pkg::result_t  push_data,
	output logic               full,
	output logic               head_valid,
	input  logic               head_ready,
	output wbps_pkg::result_t  head_data
);

	wbps_pkg::result_t data0_q;
	wbps_pkg::result_t data1_q;
	logic [1:0]        count_q;
	logic              pop;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_data  = data0_q;
	assign pop        = head_valid && head_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b10: begin
				if (count_q == 2'd0) data0_q <= push_data;
				else                 data1_q <= push_data;
			end
			2'b01: begin
				data0_q <= data1_q;
			end
			2'b11: begin
				// one entry held, leaving and replaced in the same cycle
				data0_q <= push_data;
			end
			default: begin
				data0_q <= data0_q;
			end
		endcase
	end

endmodule

>>> rtl/wildcard_byte_pattern_scanner_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner_unit
// Scans a byte stream for a wildcard pattern of up to 16 bytes.
// ----------------------------------------------------------------------------
// Image bytes arrive on the s_ stream, one per request, s_tlast on the final
// byte. The first time the newest pattern_length bytes match the pattern
// (bytes with a clear care bit are wildcards) one result goes out on m_:
// m_tuser = 1 and m_tdata = offset of the match start. An image that ends
// without a match gives one result with m_tuser = 0, m_tdata = 0. After the
// last byte the window and byte count clear for the next image.
// The window compare runs in the cycle a byte is accepted; the result is
// registered in the result buffer. One byte per cycle is taken while s_tready
// is high. Results queue in a two-entry buffer; s_tready drops only while
// both entries wait for the receiver, so a stall on m_ stops input after
// two pending results. Registers are written over cfg_ (index 0 pattern
// low, 1 pattern high, 2 care mask, 3 pattern length); the user must do so
// only while no image is in flight, the block does not enforce it. cfg_ready
// is always high. Reset clears the window, count and registers (length = 1).
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	// image input
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,   // [7:0] image_byte
	input  logic                              s_tlast,   // last_byte
	// result output
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [wbps_pkg::CNT_W-1:0]        m_tdata,   // [31:0] match_offset
	output logic                              m_tuser,   // [0] found
	// configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [wbps_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [wbps_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic [63:0]                      pat_lo_q;
	logic [63:0]                      pat_hi_q;
	logic [wbps_pkg::PAT_MAX-1:0]     care_q;
	logic [wbps_pkg::CFG_LEN_W-1:0]   len_q;

	wbps_pkg::byte_vec_t              window_q;
	wbps_pkg::byte_vec_t              window_nx;
	wbps_pkg::byte_vec_t              pattern;
	logic [wbps_pkg::CNT_W-1:0]       seen_q;
	logic [wbps_pkg::CNT_W-1:0]       seen_nx;
	logic [wbps_pkg::CNT_W-1:0]       len_ext;
	logic                             reported_q;
	logic [wbps_pkg::LEN_W-1:0]       used_len;
	logic                             win_match;
	logic                             hit;
	logic                             accept;
	logic                             res_push;
	wbps_pkg::result_t                res;
	wbps_pkg::result_t                head;
	logic                             buf_full;

	// ---------------- configuration ----------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			care_q   <= '0;
			len_q    <= wbps_pkg::CFG_LEN_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				wbps_pkg::REG_PATTERN_LOW:  pat_lo_q <= cfg_data;
				wbps_pkg::REG_PATTERN_HIGH: pat_hi_q <= cfg_data;
				wbps_pkg::REG_CARE_MASK:    care_q   <= cfg_data[wbps_pkg::PAT_MAX-1:0];
				wbps_pkg::REG_PATTERN_LEN:  len_q    <= cfg_data[wbps_pkg::CFG_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign pattern  = {pat_hi_q, pat_lo_q};
	assign used_len = (len_q > wbps_pkg::CFG_LEN_W'(wbps_pkg::PAT_MAX))
		? wbps_pkg::LEN_W'(wbps_pkg::PAT_MAX) : wbps_pkg::LEN_W'(len_q);
	assign len_ext  = {{(wbps_pkg::CNT_W-wbps_pkg::LEN_W){1'b0}}, used_len};

	// ---------------- scan ----------------
	assign accept  = s_tvalid && s_tready;
	assign s_tready = !buf_full;

	assign window_nx = {window_q[wbps_pkg::PAT_MAX-2:0], s_tdata};
	// count saturates at all ones
	assign seen_nx   = (&seen_q) ? seen_q : seen_q + wbps_pkg::CNT_W'(1);

	wbps_match u_match (
		.win      (window_nx),
		.pattern  (pattern),
		.care     (care_q),
		.used_len (used_len),
		.match    (win_match)
	);

	assign hit        = !reported_q && win_match && (seen_nx >= len_ext);
	assign res.found  = hit;
	assign res.offset = hit ? (seen_nx - len_ext) : '0;
	assign res_push   = accept && (hit || (s_tlast && !reported_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q   <= '0;
			seen_q     <= '0;
			reported_q <= 1'b0;
		end else if (accept) begin
			if (s_tlast) begin
				window_q   <= '0;
				seen_q     <= '0;
				reported_q <= 1'b0;
			end else begin
				window_q   <= window_nx;
				seen_q     <= seen_nx;
				reported_q <= reported_q || hit;
			end
		end
	end

	// ---------------- result buffer ----------------
	wbps_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (res_push),
		.push_data  (res),
		.full       (buf_full),
		.head_valid (m_tvalid),
		.head_ready (m_tready),
		.head_data  (head)
	);

	assign m_tdata = head.offset;
	assign m_tuser = head.found;

	// ---------------- assertions ----------------
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !buf_full)
		else $error("result pushed into full buffer");

	a_found_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && hit && !s_tlast) |=> reported_q)
		else $error("match not recorded as reported");

	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tlast) |=> (seen_q == '0) && !reported_q)
		else $error("scanner not rearmed after last byte");

	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == '0))
		else $error("not-found result carries nonzero offset");

endmodule

>>> tb/wildcard_byte_pattern_scanner_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner_unit_test
// Self-checking bench for the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
// Images are streamed into s_ one byte per request. A scoreboard keeps its
// own copy of the pattern registers, byte window and byte count, predicts the
// found / not-found result of every image and checks m_ results in order.
// A short directed set covers reset defaults, zero and oversized pattern
// length, full 16-byte match on the last byte, wildcards, repeated matches,
// short images and an out-of-range register write. Random images follow,
// most of them carrying planted (or deliberately broken) copies of a random
// pattern, with random stalls on both streams.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner_unit_test;

	localparam int ITEM_TARGET  = 1150;
	localparam int QUIET_FROM   = 1000;      // no stalls after this many bytes
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 400000;

	class scan_scoreboard;
		logic [wbps_pkg::CFG_DATA_W-1:0] pat_lo;
		logic [wbps_pkg::CFG_DATA_W-1:0] pat_hi;
		logic [wbps_pkg::PAT_MAX-1:0]    care;
		logic [wbps_pkg::CFG_LEN_W-1:0]  pat_len;
		logic [7:0]                      window [wbps_pkg::PAT_MAX];   // entry 0 is newest
		logic [wbps_pkg::CNT_W-1:0]      seen;
		bit                              reported;
		wbps_pkg::result_t               pending [$];
		int                              errors;
		int                              checked;
		int                              hits;
		int                              misses;

		function new();
			pat_lo   = '0;
			pat_hi   = '0;
			care     = '0;
			pat_len  = wbps_pkg::CFG_LEN_W'(1);
			foreach (window[k]) window[k] = 8'h00;
			seen     = '0;
			reported = 1'b0;
			errors   = 0;
			checked  = 0;
			hits     = 0;
			misses   = 0;
		endfunction

		function int used_len();
			return (pat_len > wbps_pkg::PAT_MAX) ? wbps_pkg::PAT_MAX : int'(pat_len);
		endfunction

		function logic [7:0] pat_byte(int j);
			logic [2*wbps_pkg::CFG_DATA_W-1:0] pat;
			pat = {pat_hi, pat_lo};
			return pat[8*j +: 8];
		endfunction

		function void set_reg(logic [wbps_pkg::CFG_IDX_W-1:0] idx,
			logic [wbps_pkg::CFG_DATA_W-1:0] val);
			case (idx)
				wbps_pkg::REG_PATTERN_LOW:  pat_lo  = val;
				wbps_pkg::REG_PATTERN_HIGH: pat_hi  = val;
				wbps_pkg::REG_CARE_MASK:    care    = val[wbps_pkg::PAT_MAX-1:0];
				wbps_pkg::REG_PATTERN_LEN:  pat_len = val[wbps_pkg::CFG_LEN_W-1:0];
				default: ;
			endcase
		endfunction

		function void take_byte(logic [7:0] b, bit last);
			int                len;
			bit                hit;
			wbps_pkg::result_t r;
			for (int k = wbps_pkg::PAT_MAX - 1; k > 0; k--) window[k] = window[k-1];
			window[0] = b;
			if (seen != '1) seen++;
			len = used_len();
			hit = (len != 0) && (seen >= len);
			// pattern byte j arrived len-1-j bytes ago
			for (int j = 0; j < len; j++)
				if (care[j] && window[len-1-j] != pat_byte(j)) hit = 1'b0;
			if (!reported && hit) begin
				reported = 1'b1;
				r.found  = 1'b1;
				r.offset = seen - wbps_pkg::CNT_W'(len);
				pending  = {pending, r};
				hits++;
			end
			if (last) begin
				if (!reported) begin
					r.found  = 1'b0;
					r.offset = '0;
					pending  = {pending, r};
					misses++;
				end
				foreach (window[k]) window[k] = 8'h00;
				seen     = '0;
				reported = 1'b0;
			end
		endfunction

		function void fail(string msg);
			errors++;
			if (errors <= 10) $display("MISMATCH: %s", msg);
		endfunction

		function void check_result(logic found, logic [wbps_pkg::CNT_W-1:0] offset);
			wbps_pkg::result_t want;
			if (pending.size() == 0) begin
				fail($sformatf("unexpected result found=%0b offset=%0d", found, offset));
				return;
			end
			want = pending.pop_front();
			checked++;
			if (found !== want.found || offset !== want.offset)
				fail($sformatf({"result %0d: expected found=%0b offset=%0d, ",
					"got found=%0b offset=%0d"},
					checked, want.found, want.offset, found, offset));
		endfunction
	endclass

	logic                            clk;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [7:0]                      s_tdata;
	logic                            s_tlast;
	logic                            m_tvalid;
	logic                            m_tready;
	logic [wbps_pkg::CNT_W-1:0]      m_tdata;
	logic                            m_tuser;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [wbps_pkg::CFG_DATA_W-1:0] cfg_data;

	scan_scoreboard sb = new();
	bit idle_on;
	int items_sent;
	int images;
	int writes;
	int cycles;

	wildcard_byte_pattern_scanner_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// result monitor and watchdog
	always @(posedge clk) begin
		cycles++;
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, sb.pending.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver backpressure in bursts
	initial begin
		int hold;
		hold     = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				hold = $urandom_range(0, 14);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic write_reg(input logic [wbps_pkg::CFG_IDX_W-1:0] idx,
		input logic [wbps_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
		writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// s_tvalid stays high between bytes unless a gap is inserted
	task automatic send_image(input logic [7:0] img [$]);
		int gap;
		foreach (img[i]) begin
			if (idle_on && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 15);
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			s_tvalid <= 1'b1;
			s_tdata  <= img[i];
			s_tlast  <= (i == img.size() - 1);
			do @(posedge clk); while (!s_tready);
			sb.take_byte(img[i], i == img.size() - 1);
			items_sent++;
		end
		images++;
	endtask

	// registers change only once every result is out and the pipe is empty
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [wbps_pkg::CFG_DATA_W-1:0] rand_word();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	initial begin
		logic [7:0]                      img [$];
		logic [wbps_pkg::CFG_DATA_W-1:0] v;
		logic [7:0]                      bg_byte;
		int                              img_len;
		int                              len;
		int                              pos;
		int                              kind;
		int                              j;
		bit                              alpha;

		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tlast   = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		idle_on   = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// reset defaults: length 1, all wildcards, so the first byte matches
		send_image('{8'hFF});
		drain();

		// zero length never matches
		write_reg(wbps_pkg::REG_PATTERN_LEN, '0);
		send_image('{8'h00, 8'hFF});
		drain();

		// oversized length saturates to 16; full match lands on the last byte
		write_reg(wbps_pkg::REG_PATTERN_LOW, 64'hFF00_FF00_FF00_FF00);
		write_reg(wbps_pkg::REG_PATTERN_HIGH, 64'h00FF_00FF_00FF_00FF);
		write_reg(wbps_pkg::REG_CARE_MASK, 64'hFFFF);
		write_reg(wbps_pkg::REG_PATTERN_LEN, 64'd31);
		img = {};
		for (int i = 0; i < wbps_pkg::PAT_MAX; i++) img = {img, sb.pat_byte(i)};
		send_image(img);
		drain();

		// AA ?? 55 with middle wildcard; second match in the image is ignored
		write_reg(wbps_pkg::REG_PATTERN_LOW, 64'h0000_0000_0055_33AA);
		write_reg(wbps_pkg::REG_CARE_MASK, 64'h0005);
		write_reg(wbps_pkg::REG_PATTERN_LEN, 64'd3);
		send_image('{8'hAA, 8'h00, 8'h55, 8'hAA, 8'hFF, 8'h55});
		drain();
		// write to an unknown index must not disturb the pattern
		write_reg('1, '1);
		send_image('{8'hAA, 8'h00});

		while (items_sent < ITEM_TARGET) begin
			idle_on = (items_sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 2) != 0) begin
				drain();
				if ($urandom_range(0, 1)) write_reg(wbps_pkg::REG_PATTERN_LOW, rand_word());
				if ($urandom_range(0, 1)) write_reg(wbps_pkg::REG_PATTERN_HIGH, rand_word());
				if ($urandom_range(0, 1)) begin
					case ($urandom_range(0, 4))
						0:       v = '0;
						1:       v = 64'hFFFF;
						2:       v = 64'(16'hFFFF ^ (16'h1 << $urandom_range(0, 15)));
						default: v = 64'($urandom_range(0, 16'hFFFF));
					endcase
					write_reg(wbps_pkg::REG_CARE_MASK, v);
				end
				if ($urandom_range(0, 1)) begin
					case ($urandom_range(0, 9))
						0:       v = '0;
						1:       v = 64'($urandom_range(wbps_pkg::PAT_MAX + 1, 31));
						2:       v = 64'(wbps_pkg::PAT_MAX);
						3:       v = 64'd1;
						default: v = 64'($urandom_range(1, wbps_pkg::PAT_MAX));
					endcase
					write_reg(wbps_pkg::REG_PATTERN_LEN, v);
				end
				if ($urandom_range(0, 15) == 0)
					write_reg(wbps_pkg::CFG_IDX_W'($urandom_range(
						int'(wbps_pkg::REG_PATTERN_LEN) + 1,
						(1 << wbps_pkg::CFG_IDX_W) - 1)), rand_word());
			end

			len     = sb.used_len();
			kind    = $urandom_range(0, 9);     // 0..5 clean copy, 6..7 broken, 8..9 noise
			alpha   = $urandom_range(0, 1);     // background drawn from pattern bytes
			img_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 64)
				: $urandom_range(1, 24);
			if (len > 0 && kind < 8 && img_len < len) img_len = len + $urandom_range(0, 8);
			img = {};
			for (int i = 0; i < img_len; i++) begin
				bg_byte = alpha ? sb.pat_byte($urandom_range(0, wbps_pkg::PAT_MAX - 1))
					: 8'($urandom);
				img = {img, bg_byte};
			end
			if (len > 0 && kind < 8) begin
				repeat ((kind < 2) ? 2 : 1) begin
					pos = $urandom_range(0, img_len - len);
					for (j = 0; j < len; j++)
						if (sb.care[j]) img[pos+j] = sb.pat_byte(j);
					if (kind >= 6) begin
						j = $urandom_range(0, len - 1);
						img[pos+j] = img[pos+j] ^ 8'(1 << $urandom_range(0, 7));
					end
				end
			end
			send_image(img);
		end

		idle_on = 1'b0;
		drain();
		$display("Scanned %0d bytes in %0d images with %0d register writes.",
			items_sent, images, writes);
		$display("Checked %0d results: %0d matches found, %0d images without a match.",
			sb.checked, sb.hits, sb.misses);
		if (sb.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches in total", sb.errors);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
